### rtl/core/eifx_pkg.sv
// constants for the 2d euler flux pipeline: register map and gamma format
// no dependencies
`default_nettype none

package eifx_pkg;

  localparam int GAMMA_BITS = 18;
  localparam int GAMMA_FRAC = 16;
  localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = 18'd26214;

  localparam int ADDR_BITS = 3;
  localparam logic REG_GAMMA = 1'b0;

endpackage

`default_nettype wire

### rtl/core/euler_inviscid_flux_2d.sv
// throughput: one node per cycle; a restoring divider with one quotient bit per stage
// feeds eight arithmetic stages, all advancing together while the output is free or taken
// reset: rst (synchronous, active high) clears all valid bits and loads gamma (the gamma-1 factor)
// with 0.4; payload registers are not reset
// depends on eifx_pkg
`default_nettype none

module euler_inviscid_flux_2d #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  // s_tdata: density, momentum_x, momentum_y, total_energy (lowest first)
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire logic [((4*WORD_BITS+7)/8)*8-1:0] s_tdata,
  // m_tdata: xflux_mass, xflux_mom_x, xflux_mom_y, xflux_energy,
  //          yflux_mass, yflux_mom_x, yflux_mom_y, yflux_energy (lowest first)
  // m_tuser: bad_density, saturated (lowest first)
  output logic      m_tvalid,
  input  wire logic m_tready,
  output logic [((8*WORD_BITS+7)/8)*8-1:0] m_tdata,
  output logic [1:0] m_tuser,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [eifx_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int NB = W + F;
  localparam int PW = (2*W > NB) ? 2*W : NB;
  localparam int OUT_BITS = ((8*W+7)/8)*8;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = ~MAXV;

  function automatic logic [W-1:0] magw(input logic [W-1:0] a);
    magw = a[W-1] ? (~a + 1'b1) : a;
  endfunction

  // clamp a sign and magnitude to the word range, top bit flags the clamp
  function automatic logic [W:0] pack(input logic neg, input logic [PW-1:0] m);
    logic [PW-1:0] lim;
    logic [W-1:0] mv;
    logic ov;
    lim = neg ? (PW'(1) << (W-1)) : ((PW'(1) << (W-1)) - PW'(1));
    ov = m > lim;
    mv = ov ? lim[W-1:0] : m[W-1:0];
    pack = {ov, neg ? (~mv + 1'b1) : mv};
  endfunction

  function automatic logic [W:0] mul_sh(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input int s);
    logic [2*W-1:0] pr;
    pr = {{W{1'b0}}, magw(a)} * {{W{1'b0}}, magw(b)};
    pr = pr >> s;
    mul_sh = pack(a[W-1] ^ b[W-1], PW'(pr));
  endfunction

  function automatic logic [W:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W-1:0] s;
    s = a + b;
    if (a[W-1] == b[W-1] && s[W-1] != a[W-1]) sat_add = {1'b1, a[W-1] ? MINV : MAXV};
    else sat_add = {1'b0, s};
  endfunction

  function automatic logic [W:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W-1:0] s;
    s = a - b;
    if (a[W-1] != b[W-1] && s[W-1] != a[W-1]) sat_sub = {1'b1, a[W-1] ? MINV : MAXV};
    else sat_sub = {1'b0, s};
  endfunction

  // configuration
  logic [eifx_pkg::GAMMA_BITS-1:0] gamma;
  logic [W-1:0] gamma_w;

  assign pready = 1'b1;
  assign gamma_w = W'(gamma);

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= eifx_pkg::GAMMA_RESET;
    end else if (psel && penable && pwrite && paddr[2] == eifx_pkg::REG_GAMMA) begin
      gamma <= pwdata[eifx_pkg::GAMMA_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == eifx_pkg::REG_GAMMA) prdata = 32'(gamma);
  end

  // whole pipeline moves together unless the output holds an untaken result
  logic adv;
  logic h_vld;
  assign adv = !h_vld || m_tready;
  assign s_tready = adv;

  // divider: stage k settles quotient bit NB-1-k of u and v
  logic [NB:0]    d_vld;
  logic [W-1:0]   d_rho [NB+1];
  logic [W-1:0]   d_mx  [NB+1];
  logic [W-1:0]   d_my  [NB+1];
  logic [W-1:0]   d_en  [NB+1];
  logic [NB-1:0]  d_nu  [NB+1];
  logic [NB-1:0]  d_nv  [NB+1];
  logic [NB-1:0]  d_qu  [NB+1];
  logic [NB-1:0]  d_qv  [NB+1];
  logic [W-1:0]   d_ru  [NB+1];
  logic [W-1:0]   d_rv  [NB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld[0] <= 1'b0;
    end else if (adv) begin
      d_vld[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_rho[0] <= s_tdata[W-1:0];
      d_mx[0]  <= s_tdata[2*W-1:W];
      d_my[0]  <= s_tdata[3*W-1:2*W];
      d_en[0]  <= s_tdata[4*W-1:3*W];
      d_nu[0]  <= {magw(s_tdata[2*W-1:W]), {F{1'b0}}};
      d_nv[0]  <= {magw(s_tdata[3*W-1:2*W]), {F{1'b0}}};
      d_qu[0]  <= '0;
      d_qv[0]  <= '0;
      d_ru[0]  <= '0;
      d_rv[0]  <= '0;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_div
    logic [W-1:0] ru_sh, rv_sh;
    logic ge_u, ge_v;

    always_comb begin
      ru_sh = {d_ru[k][W-2:0], d_nu[k][NB-1]};
      rv_sh = {d_rv[k][W-2:0], d_nv[k][NB-1]};
      ge_u = ru_sh >= d_rho[k];
      ge_v = rv_sh >= d_rho[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[k+1] <= 1'b0;
      end else if (adv) begin
        d_vld[k+1] <= d_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_rho[k+1] <= d_rho[k];
        d_mx[k+1]  <= d_mx[k];
        d_my[k+1]  <= d_my[k];
        d_en[k+1]  <= d_en[k];
        d_nu[k+1]  <= d_nu[k] << 1;
        d_nv[k+1]  <= d_nv[k] << 1;
        d_qu[k+1]  <= {d_qu[k][NB-2:0], ge_u};
        d_qv[k+1]  <= {d_qv[k][NB-2:0], ge_v};
        d_ru[k+1]  <= ge_u ? ru_sh - d_rho[k] : ru_sh;
        d_rv[k+1]  <= ge_v ? rv_sh - d_rho[k] : rv_sh;
      end
    end
  end

  // stage a: clamp quotients
  logic a_vld, a_bad, a_sat;
  logic [W-1:0] a_rho, a_mx, a_my, a_en, a_u, a_v;
  logic [W:0] pu, pv;
  always_comb begin
    pu = pack(d_mx[NB][W-1], PW'(d_qu[NB]));
    pv = pack(d_my[NB][W-1], PW'(d_qv[NB]));
  end

  // stage b: squares and momentum products
  logic b_vld, b_bad, b_sat;
  logic [W-1:0] b_rho, b_mx, b_my, b_en, b_u, b_v;
  logic [W-1:0] b_uu, b_vv, b_mxu, b_mxv, b_myu, b_myv;
  logic [W:0] m_uu, m_vv, m_mxu, m_mxv, m_myu, m_myv;
  always_comb begin
    m_uu  = mul_sh(a_u, a_u, F);
    m_vv  = mul_sh(a_v, a_v, F);
    m_mxu = mul_sh(a_mx, a_u, F);
    m_mxv = mul_sh(a_mx, a_v, F);
    m_myu = mul_sh(a_my, a_u, F);
    m_myv = mul_sh(a_my, a_v, F);
  end

  // stage c: speed squared
  logic c_vld, c_bad, c_sat;
  logic [W-1:0] c_rho, c_mx, c_my, c_en, c_u, c_v, c_s;
  logic [W-1:0] c_mxu, c_mxv, c_myu, c_myv;
  logic [W:0] r_s;
  assign r_s = sat_add(b_uu, b_vv);

  // stage d: kinetic energy
  logic d2_vld, d2_bad, d2_sat;
  logic [W-1:0] d2_mx, d2_my, d2_en, d2_u, d2_v, d2_ke;
  logic [W-1:0] d2_mxu, d2_mxv, d2_myu, d2_myv;
  logic [W:0] r_ke;
  assign r_ke = mul_sh(c_rho, c_s, F + 1);

  // stage e: internal energy
  logic e_vld, e_bad, e_sat;
  logic [W-1:0] e_mx, e_my, e_en, e_u, e_v, e_dd;
  logic [W-1:0] e_mxu, e_mxv, e_myu, e_myv;
  logic [W:0] r_dd;
  assign r_dd = sat_sub(d2_en, d2_ke);

  // stage f: pressure
  logic f_vld, f_bad, f_sat;
  logic [W-1:0] f_mx, f_my, f_en, f_u, f_v, f_p;
  logic [W-1:0] f_mxu, f_mxv, f_myu, f_myv;
  logic [W:0] r_p;
  assign r_p = mul_sh(e_dd, gamma_w, eifx_pkg::GAMMA_FRAC);

  // stage g: enthalpy and pressure terms
  logic g_vld, g_bad, g_sat;
  logic [W-1:0] g_mx, g_my, g_u, g_v, g_ep, g_xmx, g_ymy, g_mxv, g_myu;
  logic [W:0] r_ep, r_xmx, r_ymy;
  always_comb begin
    r_ep  = sat_add(f_en, f_p);
    r_xmx = sat_add(f_mxu, f_p);
    r_ymy = sat_add(f_myv, f_p);
  end

  // stage h: energy fluxes, output register
  logic h_bad, h_sat;
  logic [W-1:0] h_mx, h_my, h_xmx, h_ymy, h_mxv, h_myu, h_xe, h_ye;
  logic [W:0] r_xe, r_ye;
  always_comb begin
    r_xe = mul_sh(g_ep, g_u, F);
    r_ye = mul_sh(g_ep, g_v, F);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d2_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
      h_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= d_vld[NB];
      b_vld <= a_vld;
      c_vld <= b_vld;
      d2_vld <= c_vld;
      e_vld <= d2_vld;
      f_vld <= e_vld;
      g_vld <= f_vld;
      h_vld <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_bad <= d_rho[NB] == '0 || d_rho[NB][W-1];
      a_sat <= pu[W] | pv[W];
      a_rho <= d_rho[NB];
      a_mx  <= d_mx[NB];
      a_my  <= d_my[NB];
      a_en  <= d_en[NB];
      a_u   <= pu[W-1:0];
      a_v   <= pv[W-1:0];

      b_bad <= a_bad;
      b_sat <= a_sat | m_uu[W] | m_vv[W] | m_mxu[W] | m_mxv[W] | m_myu[W] | m_myv[W];
      b_rho <= a_rho;
      b_mx  <= a_mx;
      b_my  <= a_my;
      b_en  <= a_en;
      b_u   <= a_u;
      b_v   <= a_v;
      b_uu  <= m_uu[W-1:0];
      b_vv  <= m_vv[W-1:0];
      b_mxu <= m_mxu[W-1:0];
      b_mxv <= m_mxv[W-1:0];
      b_myu <= m_myu[W-1:0];
      b_myv <= m_myv[W-1:0];

      c_bad <= b_bad;
      c_sat <= b_sat | r_s[W];
      c_rho <= b_rho;
      c_mx  <= b_mx;
      c_my  <= b_my;
      c_en  <= b_en;
      c_u   <= b_u;
      c_v   <= b_v;
      c_s   <= r_s[W-1:0];
      c_mxu <= b_mxu;
      c_mxv <= b_mxv;
      c_myu <= b_myu;
      c_myv <= b_myv;

      d2_bad <= c_bad;
      d2_sat <= c_sat | r_ke[W];
      d2_mx  <= c_mx;
      d2_my  <= c_my;
      d2_en  <= c_en;
      d2_u   <= c_u;
      d2_v   <= c_v;
      d2_ke  <= r_ke[W-1:0];
      d2_mxu <= c_mxu;
      d2_mxv <= c_mxv;
      d2_myu <= c_myu;
      d2_myv <= c_myv;

      e_bad <= d2_bad;
      e_sat <= d2_sat | r_dd[W];
      e_mx  <= d2_mx;
      e_my  <= d2_my;
      e_en  <= d2_en;
      e_u   <= d2_u;
      e_v   <= d2_v;
      e_dd  <= r_dd[W-1:0];
      e_mxu <= d2_mxu;
      e_mxv <= d2_mxv;
      e_myu <= d2_myu;
      e_myv <= d2_myv;

      f_bad <= e_bad;
      f_sat <= e_sat | r_p[W];
      f_mx  <= e_mx;
      f_my  <= e_my;
      f_en  <= e_en;
      f_u   <= e_u;
      f_v   <= e_v;
      f_p   <= r_p[W-1:0];
      f_mxu <= e_mxu;
      f_mxv <= e_mxv;
      f_myu <= e_myu;
      f_myv <= e_myv;

      g_bad <= f_bad;
      g_sat <= f_sat | r_ep[W] | r_xmx[W] | r_ymy[W];
      g_mx  <= f_mx;
      g_my  <= f_my;
      g_u   <= f_u;
      g_v   <= f_v;
      g_ep  <= r_ep[W-1:0];
      g_xmx <= r_xmx[W-1:0];
      g_ymy <= r_ymy[W-1:0];
      g_mxv <= f_mxv;
      g_myu <= f_myu;

      h_bad <= g_bad;
      h_sat <= g_sat | r_xe[W] | r_ye[W];
      h_mx  <= g_mx;
      h_my  <= g_my;
      h_xmx <= g_xmx;
      h_ymy <= g_ymy;
      h_mxv <= g_mxv;
      h_myu <= g_myu;
      h_xe  <= r_xe[W-1:0];
      h_ye  <= r_ye[W-1:0];
    end
  end

  // non-positive density forces zero fluxes and no clamp flag
  assign m_tvalid = h_vld;
  assign m_tuser = {!h_bad && h_sat, h_bad};
  assign m_tdata = h_bad ? '0 : OUT_BITS'({h_ye, h_ymy, h_myu, h_my,
                                           h_xe, h_mxv, h_xmx, h_mx});

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
    else $error("bad density result carries data or clamp flag");

  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while pipeline is stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid straight after reset");

endmodule

`default_nettype wire
